@@ rtl/shs_pkg.sv @@
// Shared types, round constants and SHA-256 helper functions for the stream hasher.
`timescale 1ns / 1ps
package shs_pkg;

  localparam logic [7:0] PAD_BYTE = 8'h80;

  // Control for the working-variable unit.
  typedef struct packed {
    logic shift;   // shift v toward v[0], shift_in enters at v[7]
    logic round;   // run one compression round
  } rnd_ctl_t;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] big_s0(input logic [31:0] x);
    big_s0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic logic [31:0] big_s1(input logic [31:0] x);
    big_s1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic logic [31:0] small_s0(input logic [31:0] x);
    small_s0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] small_s1(input logic [31:0] x);
    small_s1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

  function automatic logic [31:0] iv_const(input logic [2:0] idx);
    case (idx)
      3'd0:    iv_const = 32'h6a09e667;
      3'd1:    iv_const = 32'hbb67ae85;
      3'd2:    iv_const = 32'h3c6ef372;
      3'd3:    iv_const = 32'ha54ff53a;
      3'd4:    iv_const = 32'h510e527f;
      3'd5:    iv_const = 32'h9b05688c;
      3'd6:    iv_const = 32'h1f83d9ab;
      default: iv_const = 32'h5be0cd19;
    endcase
  endfunction

  function automatic logic [31:0] k_const(input logic [5:0] idx);
    case (idx)
      6'd0:  k_const = 32'h428a2f98;  6'd1:  k_const = 32'h71374491;
      6'd2:  k_const = 32'hb5c0fbcf;  6'd3:  k_const = 32'he9b5dba5;
      6'd4:  k_const = 32'h3956c25b;  6'd5:  k_const = 32'h59f111f1;
      6'd6:  k_const = 32'h923f82a4;  6'd7:  k_const = 32'hab1c5ed5;
      6'd8:  k_const = 32'hd807aa98;  6'd9:  k_const = 32'h12835b01;
      6'd10: k_const = 32'h243185be;  6'd11: k_const = 32'h550c7dc3;
      6'd12: k_const = 32'h72be5d74;  6'd13: k_const = 32'h80deb1fe;
      6'd14: k_const = 32'h9bdc06a7;  6'd15: k_const = 32'hc19bf174;
      6'd16: k_const = 32'he49b69c1;  6'd17: k_const = 32'hefbe4786;
      6'd18: k_const = 32'h0fc19dc6;  6'd19: k_const = 32'h240ca1cc;
      6'd20: k_const = 32'h2de92c6f;  6'd21: k_const = 32'h4a7484aa;
      6'd22: k_const = 32'h5cb0a9dc;  6'd23: k_const = 32'h76f988da;
      6'd24: k_const = 32'h983e5152;  6'd25: k_const = 32'ha831c66d;
      6'd26: k_const = 32'hb00327c8;  6'd27: k_const = 32'hbf597fc7;
      6'd28: k_const = 32'hc6e00bf3;  6'd29: k_const = 32'hd5a79147;
      6'd30: k_const = 32'h06ca6351;  6'd31: k_const = 32'h14292967;
      6'd32: k_const = 32'h27b70a85;  6'd33: k_const = 32'h2e1b2138;
      6'd34: k_const = 32'h4d2c6dfc;  6'd35: k_const = 32'h53380d13;
      6'd36: k_const = 32'h650a7354;  6'd37: k_const = 32'h766a0abb;
      6'd38: k_const = 32'h81c2c92e;  6'd39: k_const = 32'h92722c85;
      6'd40: k_const = 32'ha2bfe8a1;  6'd41: k_const = 32'ha81a664b;
      6'd42: k_const = 32'hc24b8b70;  6'd43: k_const = 32'hc76c51a3;
      6'd44: k_const = 32'hd192e819;  6'd45: k_const = 32'hd6990624;
      6'd46: k_const = 32'hf40e3585;  6'd47: k_const = 32'h106aa070;
      6'd48: k_const = 32'h19a4c116;  6'd49: k_const = 32'h1e376c08;
      6'd50: k_const = 32'h2748774c;  6'd51: k_const = 32'h34b0bcb5;
      6'd52: k_const = 32'h391c0cb3;  6'd53: k_const = 32'h4ed8aa4a;
      6'd54: k_const = 32'h5b9cca4f;  6'd55: k_const = 32'h682e6ff3;
      6'd56: k_const = 32'h748f82ee;  6'd57: k_const = 32'h78a5636f;
      6'd58: k_const = 32'h84c87814;  6'd59: k_const = 32'h8cc70208;
      6'd60: k_const = 32'h90befffa;  6'd61: k_const = 32'ha4506ceb;
      6'd62: k_const = 32'hbef9a3f7;  default: k_const = 32'hc67178f2;
    endcase
  endfunction

endpackage

@@ rtl/shs_ram.sv @@
// Generic simple dual-port RAM, one write port, one registered read port.
`timescale 1ns / 1ps
module shs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/shs_sched.sv @@
// Message schedule: 16-word shift line with in-place expansion of W.
`timescale 1ns / 1ps
module shs_sched (
  input  logic        clk,
  input  logic        shift_en,
  input  logic        load_en,
  input  logic [31:0] load_word,
  output logic [31:0] w_cur
);
  import shs_pkg::*;

  logic [31:0] w [16];
  logic [31:0] w_new;

  // w[t+16] from the current window, w[0] holding w[t]
  assign w_new = small_s1(w[14]) + w[9] + small_s0(w[1]) + w[0];
  assign w_cur = w[0];

  always_ff @(posedge clk) begin
    if (shift_en) begin
      for (int i = 0; i < 15; i++) begin
        w[i] <= w[i + 1];
      end
      w[15] <= load_en ? load_word : w_new;
    end
  end

endmodule

@@ rtl/shs_round.sv @@
// Working variables a..h and the SHA-256 round function.
`timescale 1ns / 1ps
module shs_round (
  input  logic             clk,
  input  shs_pkg::rnd_ctl_t ctl,
  input  logic [31:0]      shift_in,
  input  logic [31:0]      w,
  input  logic [31:0]      k,
  output logic [31:0]      v0
);
  import shs_pkg::*;

  logic [31:0] v [8];
  logic [31:0] t1;
  logic [31:0] t2;

  assign t1 = v[7] + big_s1(v[4]) + ((v[4] & v[5]) ^ (~v[4] & v[6])) + k + w;
  assign t2 = big_s0(v[0]) + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
  assign v0 = v[0];

  always_ff @(posedge clk) begin
    if (ctl.round) begin
      v[7] <= v[6];
      v[6] <= v[5];
      v[5] <= v[4];
      v[4] <= v[3] + t1;
      v[3] <= v[2];
      v[2] <= v[1];
      v[1] <= v[0];
      v[0] <= t1 + t2;
    end else if (ctl.shift) begin
      for (int i = 0; i < 7; i++) begin
        v[i] <= v[i + 1];
      end
      v[7] <= shift_in;
    end
  end

endmodule

@@ rtl/sha256_stream_hasher_core.sv @@
// Top level: SHA-256 over a byte stream, digest emitted as eight 32-bit words.
// Flow: a byte item is taken while idle; a full 64-byte block is then loaded,
//   run through 64 rounds and added into the chain words, with in_ready low.
// End of message: one block, or two when the pad spills into a second block or
//   the closing item completes a data block, then eight digest words, each one
//   going through a chain RAM read, a capture and a hold.
// Rate: bound by the one-round-per-cycle unit; no byte is taken during a block.
// Reset: idle, length zero, chain words read as the initial values through
//   per-word valid flags; no clearing pass, the block buffer is not cleared.
`timescale 1ns / 1ps
module sha256_stream_hasher_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        has_byte,
  input  logic        end_of_message,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] digest_word,
  output logic [2:0]  word_index,
  output logic        last_word
);
  import shs_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_LOAD, S_ROUND, S_ADD, S_EMIT_RD, S_EMIT_WT, S_EMIT_HOLD
  } state_t;

  state_t      state;
  logic [5:0]  cnt;        // load word / round / chain word / digest word
  logic [63:0] len;        // bytes in current message, wraps
  logic [23:0] pw;         // last three bytes taken, for the pad word
  logic [7:0]  hvalid;     // chain word written since message start
  logic [4:0]  fill;       // words of this block that come from the buffer
  logic        pad;        // block carries the 0x80 pad word after the fill
  logic        blen;       // block ends in the bit length (final block)
  logic        fin_pend;   // end of message seen with a full data block

  logic        acc;
  logic [63:0] len_inc;
  logic [63:0] len_next;
  logic [5:0]  cm1;
  logic [3:0]  widx;
  logic [2:0]  hidx;
  logic [2:0]  rd_sel;
  logic [63:0] bits;
  logic [31:0] padw;
  logic [31:0] load_word;
  logic [31:0] buf_q;
  logic [31:0] ch_q;
  logic [31:0] ch_word;
  logic [31:0] v0;
  logic [31:0] w_cur;
  logic        buf_we;
  logic        ch_we;
  logic        sched_shift;
  rnd_ctl_t    rctl;

  assign in_ready = (state == S_IDLE);
  assign acc      = in_valid && in_ready;
  assign len_inc  = len + 64'd1;
  assign len_next = (acc && has_byte) ? len_inc : len;
  assign cm1      = cnt - 6'd1;
  assign widx     = cm1[3:0];
  assign hidx     = cm1[2:0];
  assign bits     = {len[60:0], 3'b000};

  // Block buffer: complete big-endian words only; the open word sits in pw.
  assign buf_we = acc && has_byte && (len[1:0] == 2'd3);

  shs_ram #(.WIDTH(32), .DEPTH(16)) u_buf (
    .clk   (clk),
    .we    (buf_we),
    .waddr (len[5:2]),
    .wdata ({pw, data_byte}),
    .raddr (cnt[3:0]),
    .rdata (buf_q)
  );

  // Chaining words; an entry not yet written this message reads as the IV.
  assign rd_sel  = (state == S_EMIT_WT) ? cnt[2:0] : hidx;
  assign ch_word = hvalid[rd_sel] ? ch_q : iv_const(rd_sel);
  assign ch_we   = (state == S_ADD) && (cnt != 6'd0);

  shs_ram #(.WIDTH(32), .DEPTH(8)) u_chain (
    .clk   (clk),
    .we    (ch_we),
    .waddr (hidx),
    .wdata (ch_word + v0),
    .raddr (cnt[2:0]),
    .rdata (ch_q)
  );

  // Pad word: open bytes, 0x80, zeros
  always_comb begin
    case (len[1:0])
      2'd0:    padw = {PAD_BYTE, 24'h0};
      2'd1:    padw = {pw[7:0], PAD_BYTE, 16'h0};
      2'd2:    padw = {pw[15:0], PAD_BYTE, 8'h0};
      default: padw = {pw[23:0], PAD_BYTE};
    endcase
  end

  // Word j of the block being loaded: buffer, pad word, zero or bit length
  always_comb begin
    if ({1'b0, widx} < fill) begin
      load_word = buf_q;
    end else if (pad && ({1'b0, widx} == fill)) begin
      load_word = padw;
    end else if (blen && (widx == 4'd14)) begin
      load_word = bits[63:32];
    end else if (blen && (widx == 4'd15)) begin
      load_word = bits[31:0];
    end else begin
      load_word = 32'h0;
    end
  end

  assign sched_shift = ((state == S_LOAD) && (cnt != 6'd0)) || (state == S_ROUND);

  shs_sched u_sched (
    .clk       (clk),
    .shift_en  (sched_shift),
    .load_en   (state == S_LOAD),
    .load_word (load_word),
    .w_cur     (w_cur)
  );

  // v gets the chain words during load, rotates past the adder in S_ADD
  always_comb begin
    rctl.round = (state == S_ROUND);
    rctl.shift = ((state == S_LOAD) && (cnt != 6'd0) && (cnt <= 6'd8)) ||
                 ((state == S_ADD) && (cnt != 6'd0));
  end

  shs_round u_round (
    .clk      (clk),
    .ctl      (rctl),
    .shift_in (ch_word),
    .w        (w_cur),
    .k        (k_const(cnt)),
    .v0       (v0)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= 6'd0;
      len       <= 64'd0;
      hvalid    <= 8'h00;
      fill      <= 5'd0;
      pad       <= 1'b0;
      blen      <= 1'b0;
      fin_pend  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (acc) begin
            if (has_byte) begin
              len <= len_inc;
              pw  <= {pw[15:0], data_byte};
            end
            if (has_byte && (len[5:0] == 6'd63)) begin
              // full block of message data
              fill     <= 5'd16;
              pad      <= 1'b0;
              blen     <= 1'b0;
              fin_pend <= end_of_message;
              cnt      <= 6'd0;
              state    <= S_LOAD;
            end else if (end_of_message) begin
              fill  <= {1'b0, len_next[5:2]};
              pad   <= 1'b1;
              blen  <= (len_next[5:0] < 6'd56);
              cnt   <= 6'd0;
              state <= S_LOAD;
            end
          end
        end
        S_LOAD: begin
          if (cnt == 6'd16) begin
            cnt   <= 6'd0;
            state <= S_ROUND;
          end else begin
            cnt <= cnt + 6'd1;
          end
        end
        S_ROUND: begin
          cnt <= cnt + 6'd1;
          if (cnt == 6'd63) begin
            state <= S_ADD;
          end
        end
        S_ADD: begin
          if (cnt != 6'd0) begin
            hvalid[hidx] <= 1'b1;
          end
          if (cnt == 6'd8) begin
            cnt <= 6'd0;
            if (blen) begin
              state <= S_EMIT_RD;
            end else if (pad) begin
              // pad spilled: zero block ending in the bit length
              fill  <= 5'd0;
              pad   <= 1'b0;
              blen  <= 1'b1;
              state <= S_LOAD;
            end else if (fin_pend) begin
              fin_pend <= 1'b0;
              fill     <= {1'b0, len[5:2]};
              pad      <= 1'b1;
              blen     <= (len[5:0] < 6'd56);
              state    <= S_LOAD;
            end else begin
              state <= S_IDLE;
            end
          end else begin
            cnt <= cnt + 6'd1;
          end
        end
        S_EMIT_RD: begin
          state <= S_EMIT_WT;
        end
        S_EMIT_WT: begin
          digest_word <= ch_word;
          word_index  <= cnt[2:0];
          last_word   <= (cnt[2:0] == 3'd7);
          out_valid   <= 1'b1;
          state       <= S_EMIT_HOLD;
        end
        S_EMIT_HOLD: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            if (cnt[2:0] == 3'd7) begin
              // next message starts from the IV
              cnt    <= 6'd0;
              len    <= 64'd0;
              hvalid <= 8'h00;
              state  <= S_IDLE;
            end else begin
              cnt   <= cnt + 6'd1;
              state <= S_EMIT_RD;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

@@ rtl/shs_checker.sv @@
// Port-level checks for the stream hasher, bound to the top level.
`timescale 1ns / 1ps
module shs_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] digest_word,
  input logic [2:0]  word_index,
  input logic        last_word
);

  // a stalled digest word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(digest_word) && $stable(word_index))
    else $error("digest word changed while stalled");

  // no item taken while the digest is being delivered
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("input ready during digest output");

  a_last_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (last_word == (word_index == 3'd7)))
    else $error("last_word does not match word_index");

  a_more_words: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last_word |=> !in_ready)
    else $error("input reopened before eighth word");

  a_back_idle: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && last_word |=> in_ready)
    else $error("not idle after last digest word");

endmodule

bind sha256_stream_hasher_core shs_checker u_shs_checker (.*);

@@ tb/sv/tb_top.sv @@
// Self-checking testbench for the SHA-256 stream hasher core.
`timescale 1ns / 1ps
module tb_top;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int REPORT_LIMIT = 10;
  localparam int SETTLE_WAIT  = 200;  // covers a two-block finish

  typedef struct packed {
    logic [31:0] value;
    logic [2:0]  pos;
    logic        is_last;
  } digest_item_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  data_byte = 8'h00;
  logic        has_byte = 1'b0;
  logic        end_of_message = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;

  logic steady = 1'b0;  // when set, neither side idles
  int   error_count = 0;
  int   cycle_count = 0;

  // Digest words still owed by the core, oldest first.
  digest_item_t digest_fifo[$];

  // Hash state mirrored from the accepted item stream.
  logic [31:0] chain_word [8];
  logic [63:0] byte_total;
  logic [7:0]  msg_blk [64];

  logic [31:0] start_hash [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  logic [31:0] round_const [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  sha256_stream_hasher_core DUT (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .data_byte      (data_byte),
    .has_byte       (has_byte),
    .end_of_message (end_of_message),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .digest_word    (digest_word),
    .word_index     (word_index),
    .last_word      (last_word)
  );

  always #10 clk = ~clk;

  // ---------------------------------------------------------------- predictor

  function automatic logic [31:0] ror32(input logic [31:0] x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic void restart_message();
    chain_word = start_hash;
    byte_total = '0;
  endfunction

  // 64-round compression of msg_blk into chain_word.
  function automatic void mix_block();
    logic [31:0] w [64];
    logic [31:0] v [8];
    logic [31:0] t1, t2, s0, s1;
    for (int i = 0; i < 16; i++)
      w[i] = {msg_blk[4*i], msg_blk[4*i+1], msg_blk[4*i+2], msg_blk[4*i+3]};
    for (int i = 16; i < 64; i++) begin
      s0 = ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3);
      s1 = ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10);
      w[i] = s1 + w[i-7] + s0 + w[i-16];
    end
    v = chain_word;
    for (int i = 0; i < 64; i++) begin
      t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25)) +
           ((v[4] & v[5]) ^ (~v[4] & v[6])) + round_const[i] + w[i];
      t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22)) +
           ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++)
      chain_word[i] = chain_word[i] + v[i];
  endfunction

  // Takes one accepted item; queues eight digest words when a message closes.
  // The byte count wraps at 64 bits like the hardware counter, though no run
  // gets anywhere near that.
  function automatic void absorb_item(input logic [7:0] b, input logic hb,
                                      input logic eom);
    int          p;
    logic [63:0] bit_len;
    if (hb) begin
      p = int'(byte_total[5:0]);
      msg_blk[p] = b;
      byte_total = byte_total + 64'd1;
      if (p == 63) mix_block();
    end
    if (eom) begin
      bit_len = byte_total << 3;
      p = int'(byte_total[5:0]);
      msg_blk[p] = shs_pkg::PAD_BYTE;
      p++;
      if (p > 56) begin
        // length field does not fit: close this block and use one more
        while (p < 64) begin
          msg_blk[p] = 8'h00;
          p++;
        end
        mix_block();
        p = 0;
      end
      while (p < 56) begin
        msg_blk[p] = 8'h00;
        p++;
      end
      for (int k = 0; k < 8; k++)
        msg_blk[56 + k] = bit_len[8 * (7 - k) +: 8];
      mix_block();
      for (int k = 0; k < 8; k++)
        digest_fifo.push_back('{value: chain_word[k], pos: k[2:0], is_last: (k == 7)});
      restart_message();
    end
  endfunction

  function automatic void check_word(input logic [31:0] w, input logic [2:0] i,
                                     input logic l);
    digest_item_t exp_item;
    if (digest_fifo.size() == 0) begin
      error_count++;
      if (error_count <= REPORT_LIMIT)
        $display("unexpected digest word %h index %0d last %b", w, i, l);
      return;
    end
    exp_item = digest_fifo.pop_front();
    if (w !== exp_item.value || i !== exp_item.pos || l !== exp_item.is_last) begin
      error_count++;
      if (error_count <= REPORT_LIMIT)
        $display("digest mismatch: expected word %h index %0d last %b, got %h %0d %b",
                 exp_item.value, exp_item.pos, exp_item.is_last, w, i, l);
    end
  endfunction

  // Both handshakes sampled at the rising edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) absorb_item(data_byte, has_byte, end_of_message);
      if (out_valid && out_ready) check_word(digest_word, word_index, last_word);
    end
  end

  always @(negedge clk) begin
    out_ready <= steady || ($urandom_range(99) >= 30);
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("sha256_stream_hasher_core test failed");
      $finish;
    end
  end

  // ------------------------------------------------------------------ driving

  // Called at a falling edge; returns at the falling edge after acceptance
  // with valid still high, so a following item can go out back to back.
  task automatic send_item(input logic [7:0] b, input logic hb, input logic eom);
    if (!steady && $urandom_range(99) < 30) begin
      in_valid <= 1'b0;
      @(negedge clk);
      while ($urandom_range(99) < 30) @(negedge clk);
    end
    in_valid       <= 1'b1;
    data_byte      <= b;
    has_byte       <= hb;
    end_of_message <= eom;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic stop_sending();
    in_valid <= 1'b0;
    @(negedge clk);
  endtask

  // Sender holds off until every owed digest word has come back.
  task automatic wait_drained();
    stop_sending();
    while (digest_fifo.size() != 0) @(negedge clk);
  endtask

  // Random bytes; the end mark rides on the last byte or on an empty item.
  // Noisy messages carry empty items among the bytes.
  task automatic send_message(input int len, input logic split_end, input logic noisy);
    for (int n = 0; n < len; n++) begin
      if (noisy && $urandom_range(9) == 0)
        send_item(8'($urandom_range(255)), 1'b0, 1'b0);
      send_item(8'($urandom_range(255)), 1'b1, !split_end && (n == len - 1));
    end
    if (split_end || len == 0) send_item(8'($urandom_range(255)), 1'b0, 1'b1);
  endtask

  // -------------------------------------------------------------------- tests

  task automatic test_empty_items();
    send_item(8'hff, 1'b0, 1'b0);
    send_item(8'h00, 1'b0, 1'b0);
    send_item(8'h5a, 1'b0, 1'b0);
    stop_sending();
    repeat (SETTLE_WAIT) @(negedge clk);
  endtask

  task automatic test_empty_message();
    send_item(8'ha5, 1'b0, 1'b1);
    send_item(8'h00, 1'b0, 1'b1);  // two empty messages back to back
    wait_drained();
  endtask

  task automatic test_short_messages();
    send_item(8'h00, 1'b1, 1'b1);
    send_item(8'hff, 1'b1, 1'b1);
    send_item(8'h61, 1'b1, 1'b0);
    send_item(8'h62, 1'b1, 1'b0);
    send_item(8'h63, 1'b1, 1'b0);
    send_item(8'h00, 1'b0, 1'b1);  // end mark on an empty item
    wait_drained();
  endtask

  // 55 bytes: length fills the block exactly; 56: pad spills into a second
  // block; 64: full block compressed before the pad block.
  task automatic test_block_boundaries();
    send_message(55, 1'b0, 1'b0);
    send_message(56, 1'b1, 1'b0);
    wait_drained();
    steady = 1'b1;
    send_message(64, 1'b0, 1'b0);
    wait_drained();
    steady = 1'b0;
  endtask

  task automatic test_random_messages();
    int   sent;
    int   len;
    logic split_end;
    sent = 0;
    while (sent < 100) begin
      if ($urandom_range(7) == 0)
        len = $urandom_range(70, 40);
      else
        len = $urandom_range(12);
      split_end = 1'($urandom_range(1));
      send_message(len, split_end, 1'b1);
      sent += len + ((split_end || len == 0) ? 1 : 0);
      if ($urandom_range(7) == 0) wait_drained();
    end
    wait_drained();
  endtask

  initial begin
    restart_message();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_empty_items();
    test_empty_message();
    test_short_messages();
    test_block_boundaries();
    test_random_messages();
    repeat (SETTLE_WAIT) @(negedge clk);
    if (error_count == 0 && digest_fifo.size() == 0) begin
      $display("sha256_stream_hasher_core test passed");
    end else begin
      $display("sha256_stream_hasher_core test failed");
    end
    $finish;
  end

endmodule
